// ===== sv/xenc_pkg.sv =====
// Package for the x86-64 instruction encoder: field widths, operation and
// status codes, opcode bytes and the shared request and result types.
// No dependencies.
package xenc_pkg;

  localparam int MAX_PARAMS = 6;
  localparam int MAP_SLOTS  = 6;
  localparam int REG_COUNT  = 16;
  localparam int MAX_OUT    = 12;
  localparam int COUNT_W    = 4;

  localparam int CFG_DATA_W  = 24;
  localparam int CFG_INDEX_W = 1;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARAM_MAP   = 1'd0;
  localparam logic [CFG_INDEX_W-1:0] CFG_PARAM_COUNT = 1'd1;

  typedef enum logic [3:0] {
    OP_PUSH_REG = 4'd0,
    OP_PUSH_IMM = 4'd1,
    OP_POP      = 4'd2,
    OP_CMP      = 4'd3,
    OP_JMP      = 4'd4,
    OP_JCC      = 4'd5,
    OP_XOR      = 4'd6,
    OP_ADD      = 4'd7,
    OP_SUB      = 4'd8,
    OP_IMUL     = 4'd9,
    OP_INC      = 4'd10,
    OP_DEC      = 4'd11,
    OP_MOV_IMM  = 4'd12,
    OP_MOV_REG  = 4'd13,
    OP_RET      = 4'd14
  } req_type_t;

  localparam logic [1:0] DST_REG   = 2'd0;
  localparam logic [1:0] DST_PARAM = 2'd1;
  localparam logic [1:0] SRC_REG   = 2'd0;
  localparam logic [1:0] SRC_IMM   = 2'd1;
  localparam logic [1:0] SRC_PARAM = 2'd2;

  localparam logic [1:0] IMM_8  = 2'd0;
  localparam logic [1:0] IMM_16 = 2'd1;
  localparam logic [1:0] IMM_32 = 2'd2;
  localparam logic [1:0] IMM_64 = 2'd3;

  localparam logic [1:0] OSZ_16 = 2'd0;
  localparam logic [1:0] OSZ_64 = 2'd2;

  localparam logic [3:0] COND_COUNT = 4'd10;

  typedef enum logic [1:0] {
    ST_OK      = 2'd0,
    ST_PARAM   = 2'd1,
    ST_OPERAND = 2'd2,
    ST_WIDE    = 2'd3
  } status_t;

  localparam logic [7:0] OPC_PUSH_IMM8  = 8'h6A;
  localparam logic [7:0] OPC_PUSH_IMM32 = 8'h68;
  localparam logic [7:0] OPC_REX_W      = 8'h48;
  localparam logic [7:0] OPC_GRP5       = 8'hFF;
  localparam logic [7:0] OPC_POP_RM     = 8'h8F;
  localparam logic [7:0] OPC_JMP_REL32  = 8'hE9;
  localparam logic [7:0] OPC_ESCAPE     = 8'h0F;
  localparam logic [7:0] OPC_IMUL_RR    = 8'hAF;
  localparam logic [7:0] OPC_IMUL_IMM   = 8'h69;
  localparam logic [7:0] OPC_MOV_IMM    = 8'hC7;
  localparam logic [7:0] OPC_MOV_RR     = 8'h89;
  localparam logic [7:0] OPC_CMP_RR     = 8'h39;
  localparam logic [7:0] OPC_XOR_RR     = 8'h33;
  localparam logic [7:0] OPC_ADD_RR     = 8'h01;
  localparam logic [7:0] OPC_SUB_RR     = 8'h29;
  localparam logic [7:0] OPC_GRP1_IMM8  = 8'h80;
  localparam logic [7:0] OPC_GRP1_IMM32 = 8'h81;
  localparam logic [7:0] OPC_GRP1_SIMM8 = 8'h83;
  localparam logic [7:0] OPC_RET        = 8'hC3;

  typedef logic [MAX_OUT-1:0][7:0] code_bytes_t;

  typedef struct packed {
    logic [3:0]         req_type;
    logic [1:0]         dst_kind;
    logic [3:0]         dst_index;
    logic [1:0]         src_kind;
    logic [3:0]         src_index;
    logic [63:0]        imm_value;
    logic [1:0]         imm_size;
    logic [1:0]         operand_size;
    logic signed [31:0] jump_offset;
    logic [3:0]         condition;
  } enc_req_t;

  typedef struct packed {
    code_bytes_t        bytes;
    logic [COUNT_W-1:0] len;
    status_t            status;
  } enc_result_t;

  function automatic logic [7:0] cond_opcode(input logic [3:0] cond);
    logic [7:0] opc;
    case (cond)
      4'd0: opc = 8'h8C;
      4'd1: opc = 8'h82;
      4'd2: opc = 8'h8F;
      4'd3: opc = 8'h87;
      4'd4: opc = 8'h8E;
      4'd5: opc = 8'h86;
      4'd6: opc = 8'h8D;
      4'd7: opc = 8'h83;
      4'd8: opc = 8'h84;
      4'd9: opc = 8'h85;
      default: opc = 8'h00;
    endcase
    return opc;
  endfunction

endpackage

// ===== sv/xenc_if.sv =====
// Valid/ready channel interfaces for the instruction encoder: the request
// channel and the code byte channel. Depends on nothing.
interface xenc_req_if;
  logic               valid;
  logic               ready;
  logic [3:0]         req_type;
  logic [1:0]         dst_kind;
  logic [3:0]         dst_index;
  logic [1:0]         src_kind;
  logic [3:0]         src_index;
  logic [63:0]        imm_value;
  logic [1:0]         imm_size;
  logic [1:0]         operand_size;
  logic signed [31:0] jump_offset;
  logic [3:0]         condition;

  modport source (
    output valid, req_type, dst_kind, dst_index, src_kind, src_index,
           imm_value, imm_size, operand_size, jump_offset, condition,
    input  ready
  );
  modport sink (
    input  valid, req_type, dst_kind, dst_index, src_kind, src_index,
           imm_value, imm_size, operand_size, jump_offset, condition,
    output ready
  );
endinterface

interface xenc_code_if;
  logic       valid;
  logic       ready;
  logic [7:0] code_byte;
  logic       last_byte;
  logic [1:0] status;

  modport source (output valid, code_byte, last_byte, status, input ready);
  modport sink (input valid, code_byte, last_byte, status, output ready);
endinterface

// ===== sv/xenc_encoder.sv =====
// Combinational encoder: one registered request and the parameter map in,
// the full byte sequence, its length and the status out. Uses xenc_pkg.
module xenc_encoder (
  input  xenc_pkg::enc_req_t              req,
  input  logic [xenc_pkg::CFG_DATA_W-1:0] param_reg_map,
  input  logic [2:0]                      param_count,
  output xenc_pkg::enc_result_t           result
);
  import xenc_pkg::*;

  function automatic logic [7:0] rex(input logic w, input logic [3:0] r,
                                     input logic [3:0] rm);
    return {4'h4, w, r[3], 1'b0, rm[3]};
  endfunction

  function automatic logic [7:0] modrm(input logic [2:0] r, input logic [3:0] rm);
    return {2'b11, r, rm[2:0]};
  endfunction

  function automatic code_bytes_t put_word(input code_bytes_t b, input logic [3:0] pos,
                                           input logic [31:0] w);
    code_bytes_t nb;
    nb = b;
    for (int i = 0; i < 4; i++) begin
      nb[pos + 4'(i)] = w[8*i +: 8];
    end
    return nb;
  endfunction

  logic [31:0]        map_ext;
  logic [2:0]         limit;
  logic [3:0]         d;
  logic [3:0]         s;
  status_t            d_st;
  status_t            s_st;
  code_bytes_t        b;
  logic [COUNT_W-1:0] len;
  status_t            st;
  logic [31:0]        imm_lo;
  logic [31:0]        rel;

  assign map_ext = {{(32 - CFG_DATA_W){1'b0}}, param_reg_map};
  assign imm_lo  = req.imm_value[31:0];
  assign rel     = $unsigned(req.jump_offset);

  always_comb begin
    limit = param_count;
    if (limit > 3'(MAX_PARAMS)) limit = 3'(MAX_PARAMS);
    if (limit > 3'(MAP_SLOTS)) limit = 3'(MAP_SLOTS);
  end

  always_comb begin
    d    = req.dst_index;
    d_st = ST_OK;
    if (req.dst_kind == DST_PARAM) begin
      d = map_ext[{req.dst_index[2:0], 2'b00} +: 4];
      if (req.dst_index >= {1'b0, limit}) d_st = ST_PARAM;
    end else if (req.dst_kind != DST_REG) begin
      d_st = ST_OPERAND;
    end
  end

  always_comb begin
    s    = req.src_index;
    s_st = ST_OK;
    if (req.src_kind == SRC_PARAM) begin
      s = map_ext[{req.src_index[2:0], 2'b00} +: 4];
      if (req.src_index >= {1'b0, limit}) s_st = ST_PARAM;
    end else if (req.src_kind != SRC_REG) begin
      s_st = ST_OPERAND;
    end
  end

  always_comb begin
    b   = '0;
    len = '0;
    st  = ST_OK;
    case (req.req_type)
      OP_PUSH_REG: begin
        st = d_st;
        if (d[3] || req.operand_size == OSZ_64) begin
          b[0] = rex(req.operand_size == OSZ_64, 4'd0, d);
          b[1] = OPC_GRP5;
          b[2] = modrm(3'd6, d);
          len  = 4'd3;
        end else begin
          b[0] = OPC_GRP5;
          b[1] = modrm(3'd6, d);
          len  = 4'd2;
        end
      end
      OP_PUSH_IMM: begin
        case (req.imm_size)
          IMM_8: begin
            b[0] = OPC_PUSH_IMM8;
            b[1] = req.imm_value[7:0];
            len  = 4'd2;
          end
          IMM_16: begin
            b[0] = OPC_PUSH_IMM32;
            b    = put_word(b, 4'd1, imm_lo);
            len  = 4'd5;
          end
          IMM_32: begin
            b[0] = OPC_REX_W;
            b[1] = OPC_PUSH_IMM32;
            b    = put_word(b, 4'd2, imm_lo);
            len  = 4'd6;
          end
          default: begin
            b[0] = OPC_REX_W;
            b[1] = OPC_PUSH_IMM32;
            b    = put_word(b, 4'd2, imm_lo);
            b[6] = OPC_REX_W;
            b[7] = OPC_PUSH_IMM32;
            b    = put_word(b, 4'd8, req.imm_value[63:32]);
            len  = 4'd12;
          end
        endcase
      end
      OP_POP: begin
        st = d_st;
        if (req.operand_size != OSZ_16 || d[3]) begin
          b[0] = rex(req.operand_size != OSZ_16, 4'd0, d);
          b[1] = OPC_POP_RM;
          b[2] = modrm(3'd0, d);
          len  = 4'd3;
        end else begin
          b[0] = OPC_POP_RM;
          b[1] = modrm(3'd0, d);
          len  = 4'd2;
        end
      end
      OP_JMP: begin
        b[0] = OPC_JMP_REL32;
        b    = put_word(b, 4'd1, rel);
        len  = 4'd5;
      end
      OP_JCC: begin
        if (req.condition >= COND_COUNT) st = ST_OPERAND;
        b[0] = OPC_ESCAPE;
        b[1] = cond_opcode(req.condition);
        b    = put_word(b, 4'd2, rel);
        len  = 4'd6;
      end
      OP_INC, OP_DEC: begin
        st   = d_st;
        b[0] = rex(1'b1, 4'd0, d);
        b[1] = OPC_GRP5;
        b[2] = modrm((req.req_type == OP_INC) ? 3'd0 : 3'd1, d);
        len  = 4'd3;
      end
      OP_MOV_IMM: begin
        st = d_st;
        if (st == ST_OK && req.imm_size == IMM_64) st = ST_WIDE;
        b[0] = rex(1'b1, 4'd0, d);
        b[1] = OPC_MOV_IMM;
        b[2] = modrm(3'd0, d);
        b    = put_word(b, 4'd3, imm_lo);
        len  = 4'd7;
      end
      OP_RET: begin
        b[0] = OPC_RET;
        len  = 4'd1;
      end
      OP_CMP, OP_XOR, OP_ADD, OP_SUB, OP_IMUL, OP_MOV_REG: begin
        if (d_st != ST_OK) begin
          st = d_st;
        end else if (req.src_kind == SRC_IMM) begin
          if (req.req_type == OP_XOR || req.req_type == OP_MOV_REG) begin
            st = ST_OPERAND;
          end else if (req.imm_size == IMM_64) begin
            st = ST_WIDE;
          end
          b[0] = rex(1'b1, 4'd0, d);
          case (req.req_type)
            OP_CMP: begin
              b[1] = (req.imm_size == IMM_8) ? OPC_GRP1_IMM8 : OPC_GRP1_IMM32;
              b[2] = modrm(3'd7, d);
            end
            OP_ADD: begin
              b[1] = (req.imm_size == IMM_8) ? OPC_GRP1_SIMM8 : OPC_GRP1_IMM32;
              b[2] = modrm(3'd0, d);
            end
            OP_SUB: begin
              b[1] = OPC_GRP1_IMM32;
              b[2] = modrm(3'd5, d);
            end
            default: begin
              b[0] = rex(1'b1, d, d);
              b[1] = OPC_IMUL_IMM;
              b[2] = modrm(d[2:0], d);
            end
          endcase
          if (req.imm_size == IMM_8 && (req.req_type == OP_CMP || req.req_type == OP_ADD))
            begin
            b[3] = req.imm_value[7:0];
            len  = 4'd4;
          end else begin
            b   = put_word(b, 4'd3, imm_lo);
            len = 4'd7;
          end
        end else begin
          st = s_st;
          if (req.req_type == OP_IMUL) begin
            b[0] = rex(1'b1, d, s);
            b[1] = OPC_ESCAPE;
            b[2] = OPC_IMUL_RR;
            b[3] = modrm(d[2:0], s);
            len  = 4'd4;
          end else begin
            b[0] = rex(1'b1, s, d);
            case (req.req_type)
              OP_CMP:  b[1] = OPC_CMP_RR;
              OP_XOR:  b[1] = OPC_XOR_RR;
              OP_ADD:  b[1] = OPC_ADD_RR;
              OP_SUB:  b[1] = OPC_SUB_RR;
              default: b[1] = OPC_MOV_RR;
            endcase
            b[2] = modrm(s[2:0], d);
            len  = 4'd3;
          end
        end
      end
      default: st = ST_OPERAND;
    endcase

    result.status = st;
    if (st != ST_OK) begin
      result.bytes = '0;
      result.len   = 4'd1;
    end else begin
      result.bytes = b;
      result.len   = len;
    end
  end

endmodule

// ===== sv/x64_instruction_encoder.sv =====
// Top level of the x86-64 instruction encoder. Uses xenc_pkg, xenc_if, xenc_encoder.
// A request goes through the input register, the encoder and the output byte buffer.
// Throughput: one code byte per cycle while code.ready is high; an instruction of N
// bytes (one for an error status) holds the output byte buffer until all N are taken,
// and the next request is taken into the input register meanwhile. Synchronous
// active-high reset clears the pipeline valid state and both configuration registers to zero.
module x64_instruction_encoder (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                cfg_we,
  input  logic [xenc_pkg::CFG_INDEX_W-1:0]    cfg_index,
  input  logic [xenc_pkg::CFG_DATA_W-1:0]     cfg_data,
  xenc_req_if.sink                            req,
  xenc_code_if.source                         code
);
  import xenc_pkg::*;

  logic [CFG_DATA_W-1:0] param_reg_map;
  logic [2:0]            param_count;

  enc_req_t           req_q;
  logic               req_valid;
  enc_result_t        enc_res;
  code_bytes_t        code_buf;
  logic [COUNT_W-1:0] byte_count;
  status_t            status_q;

  logic req_xfer;
  logic code_xfer;
  logic buf_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      param_reg_map <= '0;
      param_count   <= '0;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_PARAM_MAP:   param_reg_map <= cfg_data;
        CFG_PARAM_COUNT: param_count   <= cfg_data[2:0];
        default: ;
      endcase
    end
  end

  assign code_xfer = code.valid && code.ready;
  assign buf_load  = req_valid && (byte_count == '0 || (byte_count == 4'd1 && code_xfer));
  assign req.ready = !req_valid || buf_load;
  assign req_xfer  = req.valid && req.ready;

  always_ff @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else if (req_xfer) begin
      req_valid <= 1'b1;
    end else if (buf_load) begin
      req_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_xfer) begin
      req_q <= '{req_type: req.req_type, dst_kind: req.dst_kind,
                 dst_index: req.dst_index, src_kind: req.src_kind,
                 src_index: req.src_index, imm_value: req.imm_value,
                 imm_size: req.imm_size, operand_size: req.operand_size,
                 jump_offset: req.jump_offset, condition: req.condition};
    end
  end

  xenc_encoder u_encoder (
    .req           (req_q),
    .param_reg_map (param_reg_map),
    .param_count   (param_count),
    .result        (enc_res)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      byte_count <= '0;
    end else if (buf_load) begin
      byte_count <= enc_res.len;
    end else if (code_xfer) begin
      byte_count <= byte_count - 4'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (buf_load) begin
      code_buf <= enc_res.bytes;
      status_q <= enc_res.status;
    end else if (code_xfer) begin
      code_buf <= {8'h00, code_buf[MAX_OUT-1:1]};
    end
  end

  assign code.valid     = byte_count != '0;
  assign code.code_byte = code_buf[0];
  assign code.last_byte = byte_count == 4'd1;
  assign code.status    = status_q;

`ifndef SYNTH
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    byte_count <= COUNT_W'(MAX_OUT))
    else $error("byte count exceeds buffer depth");

  a_status_single: assert property (@(posedge clk) disable iff (rst)
    code.valid && status_q != ST_OK |-> byte_count == 4'd1)
    else $error("error status on a multi-byte result");

  a_stall_pending: assert property (@(posedge clk) disable iff (rst)
    !req.ready |-> req_valid && code.valid)
    else $error("request stalled with nothing pending");

  a_drain_idle: assert property (@(posedge clk) disable iff (rst)
    code_xfer && code.last_byte && !req_valid |=> !code.valid)
    else $error("output valid after final byte with no pending request");

  a_load_fills: assert property (@(posedge clk) disable iff (rst)
    buf_load |=> code.valid)
    else $error("buffer load produced no output");
`endif

endmodule

// ===== sim/tb.sv =====
// Testbench for x64_instruction_encoder: sends IR instructions on the request channel,
// predicts the machine code bytes and status of each one, and checks every code transfer.
// Depends on xenc_pkg, the channel interfaces in xenc_if and the encoder RTL.
`timescale 1ns / 100ps

module tb;
  import xenc_pkg::*;

  localparam logic [3:0] OP_UNDEFINED = 4'd15;
  localparam logic [1:0] DST_OTHER    = 2'd2;
  localparam logic [1:0] DST_OTHER_HI = 2'd3;
  localparam logic [1:0] SRC_OTHER    = 2'd3;
  localparam logic [1:0] OSZ_32       = 2'd1;
  localparam logic [1:0] OSZ_RSVD     = 2'd3;
  localparam logic [3:0] COND_LT      = 4'd0;
  localparam logic [3:0] COND_NE      = 4'd9;
  localparam logic [3:0] COND_BAD     = 4'd10;
  localparam logic [9:0][7:0] JCC_OPC = {8'h85, 8'h84, 8'h83, 8'h8D, 8'h86,
                                         8'h8E, 8'h87, 8'h8F, 8'h82, 8'h8C};
  localparam int STALL_LIMIT = 4000;
  localparam int HOLD_CYCLES = 200;
  localparam int TAIL_CYCLES = 16;

  typedef struct {
    logic [7:0] code_byte;
    logic       last_byte;
    status_t    status;
  } code_exp_t;

  logic clk = 1'b0;
  logic rst;
  logic cfg_we;
  logic [CFG_INDEX_W-1:0] cfg_index;
  logic [CFG_DATA_W-1:0]  cfg_data;

  xenc_req_if  req_ch ();
  xenc_code_if code_ch ();

  x64_instruction_encoder dut (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .req       (req_ch),
    .code      (code_ch)
  );

  always begin
    #1 clk = 1'b1;
    #1 clk = 1'b0;
  end

  logic [23:0] param_map_q;
  logic [2:0]  param_count_q;
  logic [7:0]  instr_bytes[$];
  code_exp_t   expected_code[$];
  code_exp_t   want;
  int          fail_count = 0;
  int          hold_req = 0;
  int          stall_left = 0;
  int          idle_cycles = 0;
  bit          no_idle = 1'b0;

  function automatic logic [7:0] rex_byte(input logic w, input logic [3:0] rg,
                                          input logic [3:0] rm);
    return {4'h4, w, rg[3], 1'b0, rm[3]};
  endfunction

  function automatic logic [7:0] modrm_byte(input logic [2:0] rg, input logic [3:0] rm);
    return {2'b11, rg, rm[2:0]};
  endfunction

  function automatic void emit_byte(input logic [7:0] b);
    instr_bytes.push_back(b);
  endfunction

  function automatic void emit_dword(input logic [31:0] v);
    for (int i = 0; i < 4; i++) instr_bytes.push_back(v[8*i +: 8]);
  endfunction

  function automatic status_t param_reg(input logic [3:0] idx, output logic [3:0] rg);
    int lim;
    lim = (param_count_q > MAX_PARAMS) ? MAX_PARAMS : param_count_q;
    if (lim > MAP_SLOTS) lim = MAP_SLOTS;
    rg = 4'd0;
    if (idx >= lim) return ST_PARAM;
    rg = param_map_q[4*idx +: 4];
    return ST_OK;
  endfunction

  function automatic status_t dst_reg(input logic [1:0] kind, input logic [3:0] idx,
                                      output logic [3:0] rg);
    rg = idx;
    if (kind == DST_REG) return ST_OK;
    if (kind == DST_PARAM) return param_reg(idx, rg);
    return ST_OPERAND;
  endfunction

  function automatic status_t src_reg(input logic [1:0] kind, input logic [3:0] idx,
                                      output logic [3:0] rg);
    rg = idx;
    if (kind == SRC_REG) return ST_OK;
    if (kind == SRC_PARAM) return param_reg(idx, rg);
    return ST_OPERAND;
  endfunction

  // Works out the code bytes (or the single status result) of one instruction
  // and queues them as expected code transfers.
  function automatic void encode_instr(input enc_req_t r);
    logic [3:0]  d;
    logic [3:0]  s;
    logic [31:0] lo;
    logic [31:0] tail;
    logic [7:0]  opc;
    logic        tail_on;
    logic        narrow;
    status_t     st;
    code_exp_t   e;
    instr_bytes.delete();
    lo = r.imm_value[31:0];
    tail = lo;
    tail_on = 1'b0;
    narrow = (r.imm_size == IMM_8);
    st = ST_OK;
    d = 4'd0;
    s = 4'd0;
    opc = 8'h00;
    case (r.req_type)
      OP_PUSH_REG: begin
        st = dst_reg(r.dst_kind, r.dst_index, d);
        if (d[3] || r.operand_size == OSZ_64)
          emit_byte(rex_byte(r.operand_size == OSZ_64, 4'd0, d));
        emit_byte(OPC_GRP5); emit_byte(modrm_byte(3'd6, d));
      end
      OP_PUSH_IMM: begin
        tail_on = 1'b1;
        case (r.imm_size)
          IMM_8: begin
            emit_byte(OPC_PUSH_IMM8); emit_byte(lo[7:0]);
            tail_on = 1'b0;
          end
          IMM_16: emit_byte(OPC_PUSH_IMM32);
          IMM_32: begin
            emit_byte(OPC_REX_W); emit_byte(OPC_PUSH_IMM32);
          end
          default: begin
            emit_byte(OPC_REX_W); emit_byte(OPC_PUSH_IMM32); emit_dword(lo);
            emit_byte(OPC_REX_W); emit_byte(OPC_PUSH_IMM32);
            tail = r.imm_value[63:32];
          end
        endcase
      end
      OP_POP: begin
        st = dst_reg(r.dst_kind, r.dst_index, d);
        if (r.operand_size != OSZ_16) emit_byte(rex_byte(1'b1, 4'd0, d));
        else if (d[3]) emit_byte(rex_byte(1'b0, 4'd0, d));
        emit_byte(OPC_POP_RM); emit_byte(modrm_byte(3'd0, d));
      end
      OP_JMP: begin
        emit_byte(OPC_JMP_REL32);
        tail = r.jump_offset;
        tail_on = 1'b1;
      end
      OP_JCC: begin
        if (r.condition >= COND_COUNT) begin
          st = ST_OPERAND;
        end else begin
          emit_byte(OPC_ESCAPE); emit_byte(JCC_OPC[r.condition]);
          tail = r.jump_offset;
          tail_on = 1'b1;
        end
      end
      OP_INC, OP_DEC: begin
        st = dst_reg(r.dst_kind, r.dst_index, d);
        emit_byte(rex_byte(1'b1, 4'd0, d)); emit_byte(OPC_GRP5);
        emit_byte(modrm_byte((r.req_type == OP_DEC) ? 3'd1 : 3'd0, d));
      end
      OP_MOV_IMM: begin
        st = dst_reg(r.dst_kind, r.dst_index, d);
        if (st == ST_OK && r.imm_size == IMM_64) st = ST_WIDE;
        emit_byte(rex_byte(1'b1, 4'd0, d)); emit_byte(OPC_MOV_IMM);
        emit_byte(modrm_byte(3'd0, d));
        tail_on = 1'b1;
      end
      OP_RET: emit_byte(OPC_RET);
      OP_CMP, OP_XOR, OP_ADD, OP_SUB, OP_IMUL, OP_MOV_REG: begin
        st = dst_reg(r.dst_kind, r.dst_index, d);
        if (st != ST_OK) begin
        end else if (r.src_kind == SRC_IMM) begin
          if (r.req_type == OP_XOR || r.req_type == OP_MOV_REG) st = ST_OPERAND;
          else if (r.imm_size == IMM_64) st = ST_WIDE;
          else begin
            case (r.req_type)
              OP_CMP: begin
                emit_byte(rex_byte(1'b1, 4'd0, d));
                emit_byte(narrow ? OPC_GRP1_IMM8 : OPC_GRP1_IMM32);
                emit_byte(modrm_byte(3'd7, d));
                if (narrow) emit_byte(lo[7:0]);
                else tail_on = 1'b1;
              end
              OP_ADD: begin
                emit_byte(rex_byte(1'b1, 4'd0, d));
                emit_byte(narrow ? OPC_GRP1_SIMM8 : OPC_GRP1_IMM32);
                emit_byte(modrm_byte(3'd0, d));
                if (narrow) emit_byte(lo[7:0]);
                else tail_on = 1'b1;
              end
              OP_SUB: begin
                emit_byte(rex_byte(1'b1, 4'd0, d)); emit_byte(OPC_GRP1_IMM32);
                emit_byte(modrm_byte(3'd5, d));
                tail_on = 1'b1;
              end
              default: begin
                emit_byte(rex_byte(1'b1, d, d)); emit_byte(OPC_IMUL_IMM);
                emit_byte(modrm_byte(d[2:0], d));
                tail_on = 1'b1;
              end
            endcase
          end
        end else begin
          st = src_reg(r.src_kind, r.src_index, s);
          if (r.req_type == OP_IMUL) begin
            emit_byte(rex_byte(1'b1, d, s)); emit_byte(OPC_ESCAPE);
            emit_byte(OPC_IMUL_RR); emit_byte(modrm_byte(d[2:0], s));
          end else begin
            case (r.req_type)
              OP_CMP:  opc = OPC_CMP_RR;
              OP_XOR:  opc = OPC_XOR_RR;
              OP_ADD:  opc = OPC_ADD_RR;
              OP_SUB:  opc = OPC_SUB_RR;
              default: opc = OPC_MOV_RR;
            endcase
            emit_byte(rex_byte(1'b1, s, d)); emit_byte(opc);
            emit_byte(modrm_byte(s[2:0], d));
          end
        end
      end
      default: st = ST_OPERAND;
    endcase
    if (tail_on) emit_dword(tail);
    if (st != ST_OK) begin
      e.code_byte = 8'h00;
      e.last_byte = 1'b1;
      e.status = st;
      expected_code.push_back(e);
    end else begin
      foreach (instr_bytes[k]) begin
        e.code_byte = instr_bytes[k];
        e.last_byte = (k == instr_bytes.size() - 1);
        e.status = ST_OK;
        expected_code.push_back(e);
      end
    end
  endfunction

  function automatic enc_req_t mk_instr(input logic [3:0] op, input logic [1:0] dk,
                                        input logic [3:0] di, input logic [1:0] sk,
                                        input logic [3:0] si, input logic [63:0] imm,
                                        input logic [1:0] isz, input logic [1:0] osz,
                                        input logic [31:0] off, input logic [3:0] cnd);
    enc_req_t r;
    r.req_type = op;
    r.dst_kind = dk;
    r.dst_index = di;
    r.src_kind = sk;
    r.src_index = si;
    r.imm_value = imm;
    r.imm_size = isz;
    r.operand_size = osz;
    r.jump_offset = off;
    r.condition = cnd;
    return r;
  endfunction

  // Mostly well-formed instructions with random content, with a share of bad
  // operand kinds, out-of-range parameters, wide immediates and bad conditions.
  function automatic enc_req_t rand_instr();
    enc_req_t r;
    r.req_type = ($urandom_range(0, 39) == 0) ? OP_UNDEFINED : 4'($urandom_range(0, 14));
    r.dst_kind = ($urandom_range(0, 15) == 0) ? 2'($urandom_range(2, 3))
                                              : 2'($urandom_range(0, 1));
    r.dst_index = (r.dst_kind == DST_PARAM && $urandom_range(0, 7) != 0)
                  ? 4'($urandom_range(0, 5)) : 4'($urandom);
    r.src_kind = ($urandom_range(0, 19) == 0) ? SRC_OTHER : 2'($urandom_range(0, 2));
    r.src_index = (r.src_kind == SRC_PARAM && $urandom_range(0, 7) != 0)
                  ? 4'($urandom_range(0, 5)) : 4'($urandom);
    r.imm_value = {$urandom, $urandom};
    r.imm_size = ($urandom_range(0, 9) == 0) ? IMM_64 : 2'($urandom_range(0, 2));
    r.operand_size = 2'($urandom_range(0, 3));
    r.jump_offset = $urandom;
    r.condition = ($urandom_range(0, 9) == 0) ? 4'($urandom_range(10, 15))
                                              : 4'($urandom_range(0, 9));
    return r;
  endfunction

  task automatic send_instr(input enc_req_t r);
    if (!no_idle && $urandom_range(0, 3) == 0) begin
      req_ch.valid <= 1'b0;
      repeat ($urandom_range(1, 10)) @(posedge clk);
    end
    req_ch.valid        <= 1'b1;
    req_ch.req_type     <= r.req_type;
    req_ch.dst_kind     <= r.dst_kind;
    req_ch.dst_index    <= r.dst_index;
    req_ch.src_kind     <= r.src_kind;
    req_ch.src_index    <= r.src_index;
    req_ch.imm_value    <= r.imm_value;
    req_ch.imm_size     <= r.imm_size;
    req_ch.operand_size <= r.operand_size;
    req_ch.jump_offset  <= r.jump_offset;
    req_ch.condition    <= r.condition;
    @(posedge clk);
    while (!req_ch.ready) @(posedge clk);
    encode_instr(r);
  endtask

  task automatic wait_drained();
    req_ch.valid <= 1'b0;
    while (expected_code.size() != 0) @(posedge clk);
  endtask

  task automatic set_params(input logic [23:0] map_val, input logic [2:0] cnt);
    logic [23:0] upper;
    upper = 24'($urandom);
    cfg_we    <= 1'b1;
    cfg_index <= CFG_PARAM_MAP;
    cfg_data  <= map_val;
    @(posedge clk);
    cfg_index <= CFG_PARAM_COUNT;
    cfg_data  <= {upper[23:3], cnt};
    @(posedge clk);
    cfg_we <= 1'b0;
    param_map_q = map_val;
    param_count_q = cnt;
  endtask

  // Checks each code transfer and drives ready with random stalls.
  always @(posedge clk) begin
    if (!rst && code_ch.valid && code_ch.ready) begin
      if (expected_code.size() == 0) begin
        $display("%0t: unexpected code transfer, byte %h last %b status %0d", $time,
                 code_ch.code_byte, code_ch.last_byte, code_ch.status);
        fail_count++;
      end else begin
        want = expected_code.pop_front();
        if (code_ch.code_byte !== want.code_byte) begin
          $display("%0t: code_byte expected %h, actual %h", $time, want.code_byte,
                   code_ch.code_byte);
          fail_count++;
        end
        if (code_ch.last_byte !== want.last_byte) begin
          $display("%0t: last_byte expected %b, actual %b", $time, want.last_byte,
                   code_ch.last_byte);
          fail_count++;
        end
        if (code_ch.status !== want.status) begin
          $display("%0t: status expected %0d, actual %0d", $time, want.status,
                   code_ch.status);
          fail_count++;
        end
      end
    end
    if (hold_req != 0) begin
      stall_left = hold_req;
      hold_req = 0;
    end else if (stall_left == 0 && !no_idle && $urandom_range(0, 5) == 0) begin
      stall_left = $urandom_range(1, 10);
    end
    if (stall_left != 0) begin
      code_ch.ready <= 1'b0;
      stall_left--;
    end else begin
      code_ch.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    if (rst || cfg_we || (req_ch.valid && req_ch.ready) || (code_ch.valid && code_ch.ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= STALL_LIMIT) begin
      $display("x64_instruction_encoder test failed");
      $finish;
    end
  end

  task automatic check_reset_state();
    send_instr(mk_instr(OP_PUSH_REG, DST_PARAM, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_INC, DST_REG, 4'd3, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    wait_drained();
  endtask

  task automatic check_directed();
    set_params(24'hF98310, 3'd6);
    send_instr(mk_instr(OP_PUSH_REG, DST_REG, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_PUSH_REG, DST_PARAM, 4'd5, SRC_OTHER, 4'hF, 64'd0, IMM_8,
                        OSZ_64, 32'd0, COND_LT));
    send_instr(mk_instr(OP_PUSH_IMM, DST_OTHER, 4'hF, SRC_OTHER, 4'hF, '1, IMM_8,
                        OSZ_16, 32'd0, COND_BAD));
    send_instr(mk_instr(OP_PUSH_IMM, DST_REG, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_16,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_PUSH_IMM, DST_REG, 4'd0, SRC_REG, 4'd0, 64'h80000000_7FFFFFFF,
                        IMM_32, OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_PUSH_IMM, DST_REG, 4'd0, SRC_REG, 4'd0, 64'hFEDCBA98_76543210,
                        IMM_64, OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_POP, DST_REG, 4'd8, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_POP, DST_REG, 4'd15, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_RSVD, 32'd0, COND_LT));
    send_instr(mk_instr(OP_CMP, DST_REG, 4'd15, SRC_IMM, 4'd0, 64'h80, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_CMP, DST_PARAM, 4'd3, SRC_REG, 4'd15, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_JMP, DST_REG, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'h80000000, COND_LT));
    send_instr(mk_instr(OP_JCC, DST_REG, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'h7FFFFFFF, COND_NE));
    send_instr(mk_instr(OP_JCC, DST_REG, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_BAD));
    send_instr(mk_instr(OP_XOR, DST_REG, 4'd1, SRC_IMM, 4'd0, 64'd5, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_ADD, DST_REG, 4'd9, SRC_IMM, 4'd0, 64'h7F, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_SUB, DST_PARAM, 4'd4, SRC_IMM, 4'd0, 64'h1234, IMM_16,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_IMUL, DST_PARAM, 4'd5, SRC_IMM, 4'd0, 64'hDEADBEEF, IMM_32,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_IMUL, DST_REG, 4'd12, SRC_PARAM, 4'd2, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_DEC, DST_PARAM, 4'd5, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_MOV_IMM, DST_REG, 4'd2, SRC_IMM, 4'd0, 64'd1, IMM_64,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_MOV_REG, DST_REG, 4'd15, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_RET, DST_OTHER_HI, 4'hF, SRC_OTHER, 4'hF, 64'd0, IMM_64,
                        OSZ_RSVD, 32'd0, COND_BAD));
    send_instr(mk_instr(OP_UNDEFINED, DST_REG, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_ADD, DST_OTHER, 4'd0, SRC_REG, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_SUB, DST_REG, 4'd0, SRC_OTHER, 4'd0, 64'd0, IMM_8,
                        OSZ_16, 32'd0, COND_LT));
    send_instr(mk_instr(OP_MOV_IMM, DST_PARAM, 4'd6, SRC_REG, 4'd0, 64'd0, IMM_32,
                        OSZ_32, 32'd0, COND_LT));
    send_instr(mk_instr(OP_ADD, DST_REG, 4'd3, SRC_IMM, 4'd0, 64'd0, IMM_64,
                        OSZ_16, 32'd0, COND_LT));
    wait_drained();
  endtask

  task automatic check_param_table();
    for (int phase = 0; phase < 5; phase++) begin
      case (phase)
        0: set_params(24'h000000, 3'd0);
        1: set_params(24'hFFFFFF, 3'd7);
        2: set_params(24'($urandom), 3'd1);
        3: set_params(24'($urandom), 3'd6);
        default: set_params(24'h654321, 3'd5);
      endcase
      repeat (12) send_instr(rand_instr());
      wait_drained();
    end
  endtask

  // The code side holds off for a long stretch while requests keep coming,
  // so the encoder fills up and stops taking new instructions.
  task automatic check_output_stall();
    hold_req = HOLD_CYCLES;
    repeat (16) send_instr(rand_instr());
    wait_drained();
  endtask

  task automatic check_random_stream();
    for (int n = 0; n < 370; n++) begin
      if (n % 75 == 74) begin
        wait_drained();
        set_params(24'($urandom), 3'($urandom_range(0, 7)));
      end
      if (n == 310) no_idle = 1'b1;
      send_instr(rand_instr());
    end
  endtask

  initial begin
    rst                 <= 1'b1;
    cfg_we              <= 1'b0;
    cfg_index           <= CFG_PARAM_MAP;
    cfg_data            <= '0;
    req_ch.valid        <= 1'b0;
    req_ch.req_type     <= '0;
    req_ch.dst_kind     <= '0;
    req_ch.dst_index    <= '0;
    req_ch.src_kind     <= '0;
    req_ch.src_index    <= '0;
    req_ch.imm_value    <= '0;
    req_ch.imm_size     <= '0;
    req_ch.operand_size <= '0;
    req_ch.jump_offset  <= '0;
    req_ch.condition    <= '0;
    param_map_q = '0;
    param_count_q = '0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    check_reset_state();
    check_directed();
    check_param_table();
    check_output_stall();
    check_random_stream();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fail_count == 0 && expected_code.size() == 0)
      $display("x64_instruction_encoder test passed");
    else
      $display("x64_instruction_encoder test failed");
    $finish;
  end

endmodule
